// ===== hdl/var3d_pkg.sv =====
// shared constants, codes and types for the 3d axis rotation unit
// no dependencies; compiled first

package var3d_pkg;

    // default sizes, handed to the top level as parameter defaults
    localparam int ANGLE_BITS_DEF     = 12;
    localparam int COEF_FRAC_BITS_DEF = 15;
    localparam int COMPONENT_BITS_DEF = 32;

    // pi/2 in unsigned q60
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    // rotation axis codes
    typedef enum logic [1:0] {
        OP_ROT_X = 2'd0,
        OP_ROT_Y = 2'd1,
        OP_ROT_Z = 2'd2,
        OP_NONE  = 2'd3
    } var3d_op_t;

    // stage load enables handed to the multiply-add units
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } var3d_adv_t;

    // q60 product, keeps bits 123:60 of the full product
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // one quarter-wave sine entry, elaboration time only:
    // taylor series in q60, rounded to frac fraction bits
    function automatic logic [31:0] sine_entry(input int unsigned k,
                                               input int unsigned qbits,
                                               input int unsigned frac);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  qmask;
        logic [63:0]  kk;
        int unsigned  n;
        kk    = 64'(k);
        qmask = (64'd1 << qbits) - 64'd1;
        x     = (HALF_PI_Q60 >> qbits) * kk + (((HALF_PI_Q60 & qmask) * kk) >> qbits);
        x2    = mul_q60(x, x);
        term  = x;
        sum   = x;
        for (n = 1; n < 40; n++)
        begin
            if (term != 64'd0)
            begin
                term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) != 0)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        sum = sum + (64'd1 << (59 - frac));
        return 32'(sum >> (60 - frac));
    endfunction

endpackage

// ===== hdl/var3d_in_if.sv =====
// input channel: one vector word with axis code and binary angle
// uses no package

interface var3d_in_if #(
    parameter int COMP_W  = 32,
    parameter int ANGLE_W = 12
);
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [COMP_W-1:0]  in_x;
    logic signed [COMP_W-1:0]  in_y;
    logic signed [COMP_W-1:0]  in_z;
    logic [ANGLE_W-1:0]        angle;

    modport source (output valid, output operation, output in_x, output in_y,
                    output in_z, output angle, input ready);
    modport sink   (input valid, input operation, input in_x, input in_y,
                    input in_z, input angle, output ready);
endinterface

// ===== hdl/var3d_out_if.sv =====
// output channel: one rotated vector word with saturation flag
// uses no package

interface var3d_out_if #(
    parameter int COMP_W = 32
);
    logic                      valid;
    logic                      ready;
    logic signed [COMP_W-1:0]  out_x;
    logic signed [COMP_W-1:0]  out_y;
    logic signed [COMP_W-1:0]  out_z;
    logic                      saturated;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input saturated, output ready);
endinterface

// ===== hdl/vector_axis_rotate_3d_unit.sv =====
// top level of the 3d rotation about a principal axis
// depends on var3d_pkg, var3d_in_if, var3d_out_if, var3d_sincos, var3d_mac
//
//   channel | dir | words                                  | handshake
//   in_ch   | in  | operation, in_x, in_y, in_z, angle     | valid/ready
//   out_ch  | out | out_x, out_y, out_z, saturated         | valid/ready
//
// one word enters per cycle unless a stall on out_ch.ready has filled every stage
// stages: rom read, multiply, add, shift/clip into the output register
// reset clears only the stage valid bits
// out_ch.ready low holds the output word; earlier stages keep filling bubbles,
// then stall in place so that nothing is dropped or sent twice

module vector_axis_rotate_3d_unit #(
    parameter int ANGLE_BITS     = var3d_pkg::ANGLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = var3d_pkg::COEF_FRAC_BITS_DEF,
    parameter int COMPONENT_BITS = var3d_pkg::COMPONENT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    var3d_in_if.sink    in_ch,
    var3d_out_if.source out_ch
);
    import var3d_pkg::*;

    localparam int N  = COMPONENT_BITS;
    localparam int CW = COEF_FRAC_BITS + 2;

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // payload carried alongside the arithmetic
    var3d_op_t          op1_reg, op2_reg, op3_reg;
    logic signed [N-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [N-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [N-1:0] x3_reg, y3_reg, z3_reg;

    logic signed [CW-1:0] sin_c, cos_c, nsin_c;
    logic signed [CW-1:0] ca1, ca2, cb1, cb2;
    logic signed [N-1:0]  va1, va2, vb1, vb2;
    logic signed [N-1:0]  res_a, res_b;
    logic                 sat_a, sat_b;
    var3d_adv_t           adv;

    logic signed [N-1:0] out_x_next, out_y_next, out_z_next;
    logic                sat_next;
    logic signed [N-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                sat_reg;

    // a stage loads when it is empty or its word moves on
    assign rdy4        = !v4_reg || out_ch.ready;
    assign rdy3        = !v3_reg || rdy4;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign in_ch.ready = rdy1;

    assign adv.prod_en = rdy2;
    assign adv.sum_en  = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_ch.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: coefficient lookup
    var3d_sincos #(
        .ANGLE_BITS     (ANGLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_sincos (
        .clk      (clk),
        .en       (rdy1),
        .angle    (in_ch.angle),
        .sin_coef (sin_c),
        .cos_coef (cos_c)
    );

    // word payload through the stages
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg <= var3d_op_t'(in_ch.operation);
            x1_reg  <= in_ch.in_x;
            y1_reg  <= in_ch.in_y;
            z1_reg  <= in_ch.in_z;
        end
        if (rdy2)
        begin
            op2_reg <= op1_reg;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
        end
        if (rdy3)
        begin
            op3_reg <= op2_reg;
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            z3_reg  <= z2_reg;
        end
    end

    // operand routing per axis
    assign nsin_c = -sin_c;

    always_comb
    begin
        case (op1_reg)
            OP_ROT_Y:
            begin
                ca1 = sin_c;  va1 = z1_reg;  ca2 = cos_c;  va2 = x1_reg;
                cb1 = cos_c;  vb1 = z1_reg;  cb2 = nsin_c; vb2 = x1_reg;
            end
            OP_ROT_Z:
            begin
                ca1 = cos_c;  va1 = x1_reg;  ca2 = nsin_c; va2 = y1_reg;
                cb1 = sin_c;  vb1 = x1_reg;  cb2 = cos_c;  vb2 = y1_reg;
            end
            default:
            begin
                ca1 = cos_c;  va1 = y1_reg;  ca2 = nsin_c; va2 = z1_reg;
                cb1 = sin_c;  vb1 = y1_reg;  cb2 = cos_c;  vb2 = z1_reg;
            end
        endcase
    end

    // stages 2 and 3: products and sums
    var3d_mac #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac_a (
        .clk    (clk),
        .adv    (adv),
        .coef_a (ca1),
        .comp_a (va1),
        .coef_b (ca2),
        .comp_b (va2),
        .result (res_a),
        .sat    (sat_a)
    );

    var3d_mac #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac_b (
        .clk    (clk),
        .adv    (adv),
        .coef_a (cb1),
        .comp_a (vb1),
        .coef_b (cb2),
        .comp_b (vb2),
        .result (res_b),
        .sat    (sat_b)
    );

    // place the rotated pair, axis component passes through
    always_comb
    begin
        out_x_next = x3_reg;
        out_y_next = y3_reg;
        out_z_next = z3_reg;
        sat_next   = sat_a || sat_b;
        case (op3_reg)
            OP_ROT_X:
            begin
                out_y_next = res_a;
                out_z_next = res_b;
            end
            OP_ROT_Y:
            begin
                out_x_next = res_a;
                out_z_next = res_b;
            end
            OP_ROT_Z:
            begin
                out_x_next = res_a;
                out_y_next = res_b;
            end
            default:
            begin
                sat_next = 1'b0;
            end
        endcase
    end

    // stage 4: output register
    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_ch.valid     = v4_reg;
    assign out_ch.out_x     = out_x_reg;
    assign out_ch.out_y     = out_y_reg;
    assign out_ch.out_z     = out_z_reg;
    assign out_ch.saturated = sat_reg;

    // an empty first stage always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> in_ch.ready)
        else $error("input refused with an empty first stage");

    // a blocked word in the add stage stays put
    a_hold_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy4 |=> v3_reg && $stable(x3_reg) && $stable(op3_reg))
        else $error("add stage word lost under stall");

    // a blocked word in the lookup stage keeps its coefficients
    a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(sin_c) && $stable(cos_c))
        else $error("lookup stage word lost under stall");

    // no axis: x and z pass unchanged and saturation is never flagged
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && rdy4 && (op3_reg == OP_NONE)
        |=> !sat_reg && (out_x_reg == $past(x3_reg)) && (out_z_reg == $past(z3_reg)))
        else $error("pass-through word altered");

endmodule

// ===== hdl/var3d_sincos.sv =====
// sine and cosine lookup: quarter-wave rom with two registered read ports
// depends on var3d_pkg (sine_entry)

module var3d_sincos #(
    parameter int ANGLE_BITS     = var3d_pkg::ANGLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = var3d_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [ANGLE_BITS-1:0]            angle,
    output logic signed [COEF_FRAC_BITS+1:0] sin_coef,
    output logic signed [COEF_FRAC_BITS+1:0] cos_coef
);
    import var3d_pkg::*;

    localparam int QB      = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int CW      = COEF_FRAC_BITS + 2;

    typedef logic [COEF_FRAC_BITS:0] rom_t [0:QUARTER];

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k <= QUARTER; k++)
        begin
            t[k] = (COEF_FRAC_BITS + 1)'(sine_entry(k, QB, COEF_FRAC_BITS));
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // fold an angle onto the quarter wave
    function automatic logic [QB:0] rom_index(input logic [ANGLE_BITS-1:0] a);
        logic [QB:0] r;
        r = {1'b0, a[QB-1:0]};
        return a[ANGLE_BITS-2] ? (QB + 1)'(QUARTER) - r : r;
    endfunction

    logic [ANGLE_BITS-1:0]  cos_angle;
    logic [QB:0]            sin_idx;
    logic [QB:0]            cos_idx;
    logic signed [CW-1:0]   sin_mag;
    logic signed [CW-1:0]   cos_mag;
    logic signed [CW-1:0]   sin_coef_reg;
    logic signed [CW-1:0]   cos_coef_reg;

    // cosine is sine a quarter turn ahead
    assign cos_angle = angle + ANGLE_BITS'(QUARTER);
    assign sin_idx   = rom_index(angle);
    assign cos_idx   = rom_index(cos_angle);

    // rom magnitudes, zero extended
    assign sin_mag = CW'(SINE_ROM[sin_idx]);
    assign cos_mag = CW'(SINE_ROM[cos_idx]);

    // registered rom reads, sign from the upper half turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_coef_reg <= angle[ANGLE_BITS-1] ? -sin_mag : sin_mag;
            cos_coef_reg <= cos_angle[ANGLE_BITS-1] ? -cos_mag : cos_mag;
        end
    end

    assign sin_coef = sin_coef_reg;
    assign cos_coef = cos_coef_reg;

endmodule

// ===== hdl/var3d_mac.sv =====
// two-product sum with floor shift and saturation, two register stages
// depends on var3d_pkg (var3d_adv_t)

module var3d_mac #(
    parameter int COMPONENT_BITS = var3d_pkg::COMPONENT_BITS_DEF,
    parameter int COEF_FRAC_BITS = var3d_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  var3d_pkg::var3d_adv_t            adv,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_a,
    input  logic signed [COMPONENT_BITS-1:0] comp_a,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_b,
    input  logic signed [COMPONENT_BITS-1:0] comp_b,
    output logic signed [COMPONENT_BITS-1:0] result,
    output logic                             sat
);
    import var3d_pkg::*;

    localparam int N  = COMPONENT_BITS;
    localparam int F  = COEF_FRAC_BITS;
    localparam int PW = F + 2 + N;
    localparam int SW = PW + 1;
    localparam int TW = SW - F;

    localparam logic [N-1:0] MAX_VAL = {1'b0, {(N - 1){1'b1}}};
    localparam logic [N-1:0] MIN_VAL = {1'b1, {(N - 1){1'b0}}};

    logic signed [PW-1:0] prod_a_next;
    logic signed [PW-1:0] prod_b_next;
    logic signed [PW-1:0] prod_a_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] sum_reg;
    logic signed [TW-1:0] shifted;
    logic [TW-N:0]        top_bits;
    logic                 fits;

    // multiplier stage
    assign prod_a_next = PW'(coef_a) * PW'(comp_a);
    assign prod_b_next = PW'(coef_b) * PW'(comp_b);

    always_ff @(posedge clk)
    begin
        if (adv.prod_en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // adder stage
    assign sum_next = SW'(prod_a_reg) + SW'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (adv.sum_en)
            sum_reg <= sum_next;
    end

    // floor shift and clip, registered by the caller
    assign shifted  = TW'(sum_reg >>> F);
    assign top_bits = shifted[TW-1:N-1];
    assign fits     = (&top_bits) || !(|top_bits);
    assign sat      = !fits;
    assign result   = fits ? shifted[N-1:0] : (shifted[TW-1] ? MIN_VAL : MAX_VAL);

endmodule
